/* rtl/hms_pkg.sv */
// ----------------------------------------------------------------------------
// Stopwatch package
// Request and response payloads, timer state, event codes and digit helpers.
// ----------------------------------------------------------------------------
package hms_pkg;

   localparam int SecW   = 6;
   localparam int HourW  = 10;
   localparam int AdjW   = 6;

   localparam logic [SecW-1:0]  SecMax   = SecW'(59);
   localparam logic [HourW-1:0] HourWrap = HourW'(24);

   localparam logic [2:0] EvTick   = 3'd0;
   localparam logic [2:0] EvClear  = 3'd1;
   localparam logic [2:0] EvPause  = 3'd2;
   localparam logic [2:0] EvResume = 3'd3;
   localparam logic [2:0] EvSample = 3'd4;

   localparam int AdjHourUp   = 0;
   localparam int AdjHourDown = 1;
   localparam int AdjMinUp    = 2;
   localparam int AdjMinDown  = 3;
   localparam int AdjSecUp    = 4;
   localparam int AdjSecDown  = 5;

   localparam int Div10Mul   = 205;
   localparam int Div10Shift = 11;
   localparam int Div10W     = HourW + 8;
   localparam int Mod25Mul   = 1311;
   localparam int Mod25Shift = 15;
   localparam int Mod25W     = HourW + 1 + 11;

   typedef struct packed {
      logic [2:0] mode;
      logic       toggle_button;
      logic       hour_up_button;
      logic       hour_down_button;
      logic       minute_up_button;
      logic       minute_down_button;
      logic       second_up_button;
      logic       second_down_button;
   } req_type;

   typedef struct packed {
      logic [5:0] secs;
      logic [5:0] mins;
      logic [4:0] hrs;
      logic [3:0] sec_ones;
      logic [2:0] sec_tens;
      logic [3:0] min_ones;
      logic [2:0] min_tens;
      logic [3:0] hour_ones;
      logic [1:0] hour_tens;
      logic       down_active;
      logic       buzzer_on;
      logic       is_running;
   } rsp_type;

   typedef struct packed {
      logic [SecW-1:0]  secs;
      logic [SecW-1:0]  mins;
      logic [HourW-1:0] hours;
      logic             count_down;
      logic             running;
      logic             alarm;
      logic             toggle_held;
      logic [AdjW-1:0]  adjust_held;
   } state_type;

   function automatic logic [HourW-1:0] div10(input logic [HourW-1:0] v);
      logic [Div10W-1:0] p;
      p = Div10W'(v) * Div10W'(Div10Mul);
      return HourW'(p >> Div10Shift);
   endfunction

   function automatic logic [3:0] rem10(input logic [HourW-1:0] v);
      logic [HourW-1:0] q;
      logic [HourW+3:0] m;
      q = div10(v);
      m = (HourW+4)'(q) * (HourW+4)'(10);
      return 4'(v - HourW'(m));
   endfunction

   function automatic logic [HourW-1:0] mod25(input logic [HourW:0] t);
      logic [Mod25W-1:0] p;
      logic [HourW:0]    q;
      logic [HourW+5:0]  m;
      p = Mod25W'(t) * Mod25W'(Mod25Mul);
      q = (HourW+1)'(p >> Mod25Shift);
      m = (HourW+6)'(q) * (HourW+6)'(25);
      return HourW'(t - (HourW+1)'(m));
   endfunction

endpackage

/* rtl/hms_stream_if.sv */
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface hms_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/hms_update.sv */
// ----------------------------------------------------------------------------
// Stopwatch next-state logic
// Applies one request event to the current timer state.
// ----------------------------------------------------------------------------
module hms_update (
   input  hms_pkg::req_type   req,
   input  hms_pkg::state_type cur,
   output hms_pkg::state_type nxt
);
   import hms_pkg::*;

   function automatic logic [SecW-1:0] step60(input logic [SecW-1:0] v,
                                              input logic up, input logic down);
      logic [SecW-1:0] r;
      r = v;
      if (up && !down) begin
         r = (v == SecMax) ? '0 : v + SecW'(1);
      end else if (down && !up) begin
         r = (v == '0) ? SecMax : v - SecW'(1);
      end
      return r;
   endfunction

   logic [AdjW-1:0] buttons;
   logic [AdjW-1:0] fire;
   logic [HourW:0]  hour_sum;

   always_comb begin
      nxt      = cur;
      buttons  = '0;
      fire     = '0;
      hour_sum = '0;
      buttons[AdjHourUp]   = req.hour_up_button;
      buttons[AdjHourDown] = req.hour_down_button;
      buttons[AdjMinUp]    = req.minute_up_button;
      buttons[AdjMinDown]  = req.minute_down_button;
      buttons[AdjSecUp]    = req.second_up_button;
      buttons[AdjSecDown]  = req.second_down_button;
      case (req.mode)
         EvTick: begin
            if (cur.running && !cur.count_down) begin
               if (cur.secs == SecMax) begin
                  nxt.secs = '0;
                  if (cur.mins == SecMax) begin
                     nxt.mins  = '0;
                     nxt.hours = cur.hours + HourW'(1);
                  end else begin
                     nxt.mins = cur.mins + SecW'(1);
                  end
               end else begin
                  nxt.secs = cur.secs + SecW'(1);
               end
               if (nxt.hours == HourWrap) begin
                  nxt.secs  = '0;
                  nxt.mins  = '0;
                  nxt.hours = '0;
               end
            end else if (cur.running) begin
               if (cur.secs != '0) begin
                  nxt.secs = cur.secs - SecW'(1);
               end else if (cur.mins != '0) begin
                  nxt.secs = SecMax;
                  nxt.mins = cur.mins - SecW'(1);
               end else if (cur.hours != '0) begin
                  nxt.secs  = SecMax;
                  nxt.mins  = SecMax;
                  nxt.hours = cur.hours - HourW'(1);
               end else begin
                  nxt.alarm = 1'b1;
               end
            end
         end
         EvClear: begin
            nxt.secs  = '0;
            nxt.mins  = '0;
            nxt.hours = '0;
         end
         EvPause: begin
            nxt.running = 1'b0;
         end
         EvResume: begin
            nxt.running = 1'b1;
         end
         EvSample: begin
            nxt.alarm = 1'b0;
            if (!req.toggle_button) begin
               nxt.toggle_held = 1'b0;
            end else if (!cur.toggle_held && !cur.running) begin
               nxt.count_down  = !cur.count_down;
               nxt.toggle_held = 1'b1;
            end
            if (nxt.count_down) begin
               fire             = buttons & ~cur.adjust_held;
               nxt.adjust_held  = buttons;
               hour_sum = {1'b0, cur.hours}
                        + (fire[AdjHourUp] ? (HourW+1)'(1) : '0)
                        + (fire[AdjHourDown] ? (HourW+1)'(24) : '0);
               if (fire[AdjHourUp] || fire[AdjHourDown]) begin
                  nxt.hours = mod25(hour_sum);
               end
               nxt.mins  = step60(cur.mins, fire[AdjMinUp], fire[AdjMinDown]);
               nxt.secs  = step60(cur.secs, fire[AdjSecUp], fire[AdjSecDown]);
            end
         end
         default: begin
         end
      endcase
   end

endmodule

/* rtl/hms_display.sv */
// ----------------------------------------------------------------------------
// Stopwatch display formatter
// Builds the response fields and decimal digits from the timer state.
// ----------------------------------------------------------------------------
module hms_display (
   input  hms_pkg::state_type st,
   output hms_pkg::rsp_type   rsp
);
   import hms_pkg::*;

   logic [HourW-1:0] sec_wide;
   logic [HourW-1:0] min_wide;
   logic [HourW-1:0] sec_q;
   logic [HourW-1:0] min_q;
   logic [HourW-1:0] hour_q;

   assign sec_wide = HourW'(st.secs);
   assign min_wide = HourW'(st.mins);
   assign sec_q    = div10(sec_wide);
   assign min_q    = div10(min_wide);
   assign hour_q   = div10(st.hours);

   always_comb begin
      rsp.secs        = st.secs;
      rsp.mins        = st.mins;
      rsp.hrs         = st.hours[4:0];
      rsp.sec_ones    = rem10(sec_wide);
      rsp.sec_tens    = sec_q[2:0];
      rsp.min_ones    = rem10(min_wide);
      rsp.min_tens    = min_q[2:0];
      rsp.hour_ones   = rem10(st.hours);
      rsp.hour_tens   = hour_q[1:0];
      rsp.down_active = st.count_down;
      rsp.buzzer_on   = st.alarm;
      rsp.is_running  = st.running;
   end

endmodule

/* rtl/hms_up_down_stopwatch.sv */
// ----------------------------------------------------------------------------
// Up/down hours-minutes-seconds stopwatch
// Event-driven stopwatch with count-up and count-down modes.
// ----------------------------------------------------------------------------
// Each request on req_if carries one event: a one-second tick, clear, pause,
// resume, or a sample of the push buttons. Every request produces exactly
// one response on rsp_if with the time after the event, six decimal display
// digits and the mode, buzzer and running flags.
// A request accepted at a clock edge shows its response from the next cycle
// on. Throughput is one request per cycle while rsp_if is ready; the state
// register doubles as the response register, so the next request is taken
// in the same cycle the pending response is taken.
// When the receiver stalls, the response holds and req_if.ready drops until
// rsp_if.ready returns.
// Reset clears the time to zero, selects count-up, sets the timer running,
// clears the buzzer and the button history, and empties the response slot.
// ----------------------------------------------------------------------------
module hms_up_down_stopwatch (
   input logic          clock,
   input logic          reset,
   hms_stream_if.sink   req_if,
   hms_stream_if.source rsp_if
);
   import hms_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      accept;
   req_type   req_payload;
   rsp_type   rsp_payload;

   assign req_payload   = req_if.payload;
   assign req_if.ready  = !rsp_valid_ff || rsp_if.ready;
   assign accept        = req_if.valid && req_if.ready;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.payload = rsp_payload;

   hms_update u_update (
      .req (req_payload),
      .cur (state_ff),
      .nxt (state_in)
   );

   hms_display u_display (
      .st  (state_ff),
      .rsp (rsp_payload)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '{default: '0, running: 1'b1};
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_fields_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.secs <= SecMax && state_ff.mins <= SecMax)
      else $error("seconds or minutes out of range");

   a_alarm_count_down: assert property (@(posedge clock) disable iff (reset)
      state_ff.alarm |-> state_ff.count_down)
      else $error("buzzer set in count-up mode");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request without response");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_if.ready |=> $stable(state_ff))
      else $error("state changed while response stalled");

endmodule

/* sim/hms_up_down_stopwatch_tb.sv */
// ----------------------------------------------------------------------------
// Up/down stopwatch testbench
// Drives tick, clear, pause, resume and button-sample requests into the
// stopwatch with random gaps on both channels. A behavioral copy of the timer
// predicts each response without a hand-written value; every response is
// checked field by field. A short directed sequence, mostly with hand-written
// responses, opens the run. Random bursts follow: counting runs, mode flips,
// adjust presses, settings just short of midnight, and random noise.
// ----------------------------------------------------------------------------
module hms_up_down_stopwatch_tb;
   import hms_pkg::*;

   localparam logic [2:0] EvSpare = 3'd7;

   localparam logic [6:0] BtnNone     = 7'b0000000;
   localparam logic [6:0] BtnToggle   = 7'b1000000;
   localparam logic [6:0] BtnHourUp   = 7'b0100000;
   localparam logic [6:0] BtnHourDown = 7'b0010000;
   localparam logic [6:0] BtnMinUp    = 7'b0001000;
   localparam logic [6:0] BtnMinDown  = 7'b0000100;
   localparam logic [6:0] BtnSecUp    = 7'b0000010;
   localparam logic [6:0] BtnSecDown  = 7'b0000001;
   localparam logic [6:0] BtnAll      = 7'b1111111;

   localparam int RandomTarget = 1550;
   localparam int IdlePercent  = 31;
   localparam int CalmFrom     = 600;
   localparam int CalmTo       = 900;
   localparam int StallLimit   = 2000;
   localparam int DrainCycles  = 8;
   localparam int PrintCap     = 40;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   hms_stream_if #(.payload_type(req_type)) req_if ();
   hms_stream_if #(.payload_type(rsp_type)) rsp_if ();

   hms_up_down_stopwatch i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   stim_row_type plan[$];
   rsp_type     display_q[$];
   int unsigned accepted, responses, mismatches, next_idx, directed_cnt;
   int unsigned quiet_cycles;
   int          bus_idx;

   int unsigned sec_cnt, min_cnt, hour_cnt;
   bit          down_mode, run_flag, buzz, toggle_latch;
   bit [AdjW-1:0] held;
   int unsigned up_ticks, down_ticks, rollovers, alarms, flips, adjust_steps;

   task automatic log_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PrintCap)
         $display("ERROR: %s", msg);
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         log_mismatch($sformatf("response %0d %s: got %0d, want %0d",
                                responses, name, got, want));
   endtask

   function automatic rsp_type show_time(input int unsigned h, input int unsigned m,
                                         input int unsigned s, input bit down,
                                         input bit alarm_on, input bit run);
      rsp_type r;
      r.secs        = 6'(s);
      r.mins        = 6'(m);
      r.hrs         = 5'(h);
      r.sec_ones    = 4'(s % 10);
      r.sec_tens    = 3'(s / 10);
      r.min_ones    = 4'(m % 10);
      r.min_tens    = 3'(m / 10);
      r.hour_ones   = 4'(h % 10);
      r.hour_tens   = 2'(h / 10);
      r.down_active = down;
      r.buzzer_on   = alarm_on;
      r.is_running  = run;
      return r;
   endfunction

   function automatic int unsigned nudge(input int unsigned v, input logic pressed,
                                         input int idx, input int unsigned step,
                                         input int unsigned modulus);
      if (pressed) begin
         if (!held[idx]) begin
            v = (v + step) % modulus;
            held[idx] = 1'b1;
            adjust_steps++;
         end
      end else begin
         held[idx] = 1'b0;
      end
      return v;
   endfunction

   function automatic void count_tick();
      if (run_flag && !down_mode) begin
         up_ticks++;
         sec_cnt++;
         if (sec_cnt == 60) begin
            min_cnt++;
            sec_cnt = 0;
         end
         if (min_cnt == 60) begin
            hour_cnt++;
            min_cnt = 0;
         end
         if (hour_cnt == 24) begin
            sec_cnt = 0;
            min_cnt = 0;
            hour_cnt = 0;
            rollovers++;
         end
      end else if (run_flag) begin
         down_ticks++;
         if (sec_cnt == 0 && min_cnt == 0 && hour_cnt == 0) begin
            buzz = 1'b1;
            alarms++;
         end
         if (sec_cnt > 0) begin
            sec_cnt--;
         end else if (min_cnt > 0) begin
            sec_cnt = 59;
            min_cnt--;
         end else if (hour_cnt > 0) begin
            sec_cnt = 59;
            min_cnt = 59;
            hour_cnt--;
         end
      end
   endfunction

   function automatic rsp_type predict_display(input req_type r);
      case (r.mode)
         EvTick: count_tick();
         EvClear: begin
            sec_cnt = 0;
            min_cnt = 0;
            hour_cnt = 0;
         end
         EvPause: run_flag = 1'b0;
         EvResume: run_flag = 1'b1;
         EvSample: begin
            buzz = 1'b0;
            if (r.toggle_button) begin
               if (!toggle_latch && !run_flag) begin
                  down_mode = !down_mode;
                  toggle_latch = 1'b1;
                  flips++;
               end
            end else begin
               toggle_latch = 1'b0;
            end
            if (down_mode) begin
               hour_cnt = nudge(hour_cnt, r.hour_up_button, AdjHourUp, 1, 25);
               hour_cnt = nudge(hour_cnt, r.hour_down_button, AdjHourDown, 24, 25);
               min_cnt = nudge(min_cnt, r.minute_up_button, AdjMinUp, 1, 60);
               min_cnt = nudge(min_cnt, r.minute_down_button, AdjMinDown, 59, 60);
               sec_cnt = nudge(sec_cnt, r.second_up_button, AdjSecUp, 1, 60);
               sec_cnt = nudge(sec_cnt, r.second_down_button, AdjSecDown, 59, 60);
            end
         end
         default: ;
      endcase
      return show_time(hour_cnt, min_cnt, sec_cnt, down_mode, buzz, run_flag);
   endfunction

   task automatic check_response(input rsp_type got);
      rsp_type want;
      responses++;
      if (display_q.size() == 0) begin
         log_mismatch($sformatf("response %0d arrived with no request pending", responses));
      end else begin
         want = display_q.pop_front();
         check_field("secs", got.secs, want.secs);
         check_field("mins", got.mins, want.mins);
         check_field("hrs", got.hrs, want.hrs);
         check_field("sec_ones", got.sec_ones, want.sec_ones);
         check_field("sec_tens", got.sec_tens, want.sec_tens);
         check_field("min_ones", got.min_ones, want.min_ones);
         check_field("min_tens", got.min_tens, want.min_tens);
         check_field("hour_ones", got.hour_ones, want.hour_ones);
         check_field("hour_tens", got.hour_tens, want.hour_tens);
         check_field("down_active", got.down_active, want.down_active);
         check_field("buzzer_on", got.buzzer_on, want.buzzer_on);
         check_field("is_running", got.is_running, want.is_running);
      end
   endtask

   function automatic logic [6:0] any_buttons();
      return 7'($urandom);
   endfunction

   task automatic add_row(input logic [2:0] ev, input logic [6:0] btn);
      stim_row_type row;
      row.req   = req_type'({ev, btn});
      row.typed = 1'b0;
      row.want  = '0;
      plan.push_back(row);
   endtask

   task automatic add_known(input logic [2:0] ev, input logic [6:0] btn,
                            input int unsigned h, input int unsigned m,
                            input int unsigned s, input bit down,
                            input bit alarm_on, input bit run);
      stim_row_type row;
      row.req   = req_type'({ev, btn});
      row.typed = 1'b1;
      row.want  = show_time(h, m, s, down, alarm_on, run);
      plan.push_back(row);
   endtask

   task automatic plan_directed();
      add_known(EvTick, BtnNone, 0, 0, 1, 0, 0, 1);
      add_known(EvClear, BtnAll, 0, 0, 0, 0, 0, 1);
      add_known(EvSpare, BtnAll, 0, 0, 0, 0, 0, 1);
      add_known(EvPause, BtnNone, 0, 0, 0, 0, 0, 0);
      add_known(EvTick, BtnAll, 0, 0, 0, 0, 0, 0);
      add_known(EvSample, BtnToggle, 0, 0, 0, 1, 0, 0);
      add_known(EvSample, BtnToggle | BtnHourDown, 24, 0, 0, 1, 0, 0);
      add_known(EvSample, BtnHourDown | BtnMinDown | BtnSecDown, 24, 59, 59, 1, 0, 0);
      add_known(EvSample, BtnHourUp | BtnMinUp | BtnSecUp, 0, 0, 0, 1, 0, 0);
      add_known(EvResume, BtnNone, 0, 0, 0, 1, 0, 1);
      add_known(EvTick, BtnNone, 0, 0, 0, 1, 1, 1);
      add_known(EvSample, BtnNone, 0, 0, 0, 1, 0, 1);
      add_known(EvSample, BtnToggle | BtnHourUp, 1, 0, 0, 1, 0, 1);
      add_known(EvTick, BtnNone, 0, 59, 59, 1, 0, 1);
      add_known(EvPause, BtnNone, 0, 59, 59, 1, 0, 0);
      add_known(EvSample, BtnToggle, 0, 59, 59, 0, 0, 0);
      add_known(EvResume, BtnNone, 0, 59, 59, 0, 0, 1);
      add_known(EvTick, BtnNone, 1, 0, 0, 0, 0, 1);
      // set 23:59:59 in count-down, then roll over midnight counting up
      add_row(EvPause, BtnNone);
      add_row(EvClear, BtnNone);
      add_row(EvSample, BtnNone);
      add_row(EvSample, BtnToggle | BtnHourDown);
      add_row(EvSample, BtnMinDown | BtnSecDown);
      add_row(EvSample, BtnHourDown);
      add_row(EvSample, BtnToggle);
      add_row(EvResume, BtnNone);
      add_row(EvTick, BtnNone);
   endtask

   task automatic plan_random();
      int kind;
      while (plan.size() < directed_cnt + RandomTarget) begin
         kind = $urandom_range(99);
         if (kind < 30) begin
            add_row(EvResume, any_buttons());
            repeat ($urandom_range(40, 1)) add_row(EvTick, any_buttons());
            if ($urandom_range(3) == 0)
               add_row(EvPause, any_buttons());
         end else if (kind < 45) begin
            add_row(EvPause, any_buttons());
            add_row(EvSample, any_buttons() & ~BtnToggle);
            add_row(EvSample, any_buttons() | BtnToggle);
            if ($urandom_range(1) == 0)
               add_row(EvResume, any_buttons());
         end else if (kind < 65) begin
            repeat ($urandom_range(12, 1)) add_row(EvSample, any_buttons());
         end else if (kind < 80) begin
            // flip, step each field back from zero, flip again and run
            add_row(EvClear, any_buttons());
            add_row(EvPause, any_buttons());
            add_row(EvSample, BtnNone);
            add_row(EvSample, BtnToggle);
            repeat ($urandom_range(3, 1)) begin
               add_row(EvSample, BtnHourDown);
               add_row(EvSample, BtnNone);
            end
            repeat ($urandom_range(3, 1)) begin
               add_row(EvSample, BtnMinDown);
               add_row(EvSample, BtnNone);
            end
            repeat ($urandom_range(5, 1)) begin
               add_row(EvSample, BtnSecDown);
               add_row(EvSample, BtnNone);
            end
            add_row(EvSample, BtnToggle);
            add_row(EvResume, any_buttons());
            repeat ($urandom_range(12, 1)) add_row(EvTick, any_buttons());
         end else begin
            repeat ($urandom_range(6, 1)) add_row(3'($urandom_range(7)), any_buttons());
         end
      end
   endtask

   always @(posedge clock) begin : bus_activity
      rsp_type want;
      bit      moved;
      bit      calm;
      if (reset) begin
         req_if.valid <= 1'b0;
         rsp_if.ready <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         moved = 1'b0;
         if (rsp_if.valid && rsp_if.ready) begin
            moved = 1'b1;
            check_response(rsp_if.payload);
         end
         if (req_if.valid && req_if.ready) begin
            moved = 1'b1;
            want = predict_display(req_if.payload);
            if (plan[bus_idx].typed)
               want = plan[bus_idx].want;
            display_q.push_back(want);
            accepted++;
         end
         quiet_cycles <= moved ? 0 : quiet_cycles + 1;
         calm = accepted >= CalmFrom && accepted < CalmTo;
         if (!req_if.valid || req_if.ready) begin
            if (next_idx < plan.size() && (calm || $urandom_range(99) >= IdlePercent)) begin
               req_if.valid   <= 1'b1;
               req_if.payload <= plan[next_idx].req;
               bus_idx        <= next_idx;
               next_idx++;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
         rsp_if.ready <= calm || $urandom_range(99) >= IdlePercent;
      end
   end

   initial begin : watchdog
      wait (quiet_cycles >= StallLimit);
      $display("no transfer for %0d cycles, %0d of %0d requests taken",
               StallLimit, accepted, plan.size());
      $display("status: fail");
      $finish;
   end

   initial begin : run_test
      clock          = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      sec_cnt        = 0;
      min_cnt        = 0;
      hour_cnt       = 0;
      down_mode      = 1'b0;
      run_flag       = 1'b1;
      buzz           = 1'b0;
      toggle_latch   = 1'b0;
      held           = '0;
      plan_directed();
      directed_cnt = plan.size();
      plan_random();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (accepted < plan.size() || display_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      $display("%0d requests (%0d directed), %0d up ticks, %0d down ticks, %0d rollovers",
               accepted, directed_cnt, up_ticks, down_ticks, rollovers);
      $display("%0d mode flips, %0d field steps, %0d alarms, %0d mismatches",
               flips, adjust_steps, alarms, mismatches);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* sim.f */
rtl/hms_pkg.sv
rtl/hms_stream_if.sv
rtl/hms_update.sv
rtl/hms_display.sv
rtl/hms_up_down_stopwatch.sv
sim/hms_up_down_stopwatch_tb.sv
